[hw/rtl/list_mode_char_escaper_assert.svh]
// Assertion macros shared by the list-mode character escaper checkers.
// Depends on nothing; included by the checker file.
`ifndef LIST_MODE_CHAR_ESCAPER_ASSERT_SVH
`define LIST_MODE_CHAR_ESCAPER_ASSERT_SVH

// Checked while out of reset
`define LCE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included
`define LCE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/lce_pkg.sv]
// Shared types and constants of the list-mode character escaper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lce_pkg;

   // Character codes
   localparam logic [7:0] CHAR_BS     = 8'h08;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LC_B   = 8'h62;
   localparam logic [7:0] CHAR_LC_N   = 8'h6E;
   localparam logic [7:0] CHAR_LC_T   = 8'h74;
   localparam logic [7:0] CHAR_DEL    = 8'h7F;

   // Register index (paddr bit 2) of the list mode register
   localparam logic CSR_IDX_LIST_MODE = 1'b0;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_PAIR,
      ESC_OCTAL
   } esc_kind_type;

   // One classified character, as handed from front to back
   typedef struct packed {
      logic         wrap;      // insert backslash, newline, tab first
      logic         nl_mark;   // insert backslash-n before the newline
      esc_kind_type kind;
      logic [7:0]   char_code; // original character
      logic [2:0]   len;       // bytes this transaction expands to
      logic         flush;     // flush after the final byte
   } desc_type;

   // Bytes taken by the escape part (plain character counts as one)
   function automatic logic [2:0] esc_len(esc_kind_type kind);
      logic [2:0] n;
      unique case (kind)
         ESC_PAIR:  n = 3'd2;
         ESC_OCTAL: n = 3'd4;
         default:   n = 3'd1;
      endcase
      return n;
   endfunction

   // Final byte of the expansion
   function automatic logic [7:0] final_byte(logic [7:0] c, esc_kind_type kind);
      logic [7:0] b;
      unique case (kind)
         ESC_PAIR: begin
            if (c == CHAR_BS) b = CHAR_LC_B;
            else if (c == CHAR_TAB) b = CHAR_LC_T;
            else b = CHAR_BSLASH;
         end
         ESC_OCTAL: b = CHAR_ZERO | {5'b0, c[2:0]};
         default:   b = c;
      endcase
      return b;
   endfunction

endpackage

[hw/rtl/lce_front.sv]
// Front end: accepts characters, tracks column, fill count and last byte,
// and classifies each character into a descriptor. Depends on lce_pkg.
`timescale 1ns / 1ps

module lce_front import lce_pkg::*; #(
   parameter int LINE_CHARS = 72,
   parameter int TAB_CHARS  = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       list_mode,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // char_in
   input  logic       req_tuser,   // line_start
   output logic       q_valid,
   input  logic       q_ready,
   output desc_type   q_desc
);

   localparam logic [7:0] WRAP_LIMIT  = 8'(LINE_CHARS - 4 - 2);
   localparam logic [7:0] FLUSH_LIMIT = 8'(LINE_CHARS - 2 - 4);
   localparam logic [7:0] TAB_COL     = 8'(TAB_CHARS);

   logic [7:0]   column_ff, column_in;
   logic [7:0]   fill_ff, fill_in;
   logic [7:0]   last_ff, last_in;
   logic         accept;
   logic [7:0]   col0;
   logic         is_nl;
   logic         escaping;
   logic         wrap;
   logic         nl_mark;
   esc_kind_type kind;
   logic [2:0]   len;
   logic [7:0]   fin;
   logic [7:0]   fill_sum;
   logic         flush;

   assign req_tready = q_ready;
   assign q_valid    = req_tvalid;
   assign accept     = req_tvalid && q_ready;

   // Classify the character against the current state
   always_comb begin
      col0     = req_tuser ? 8'd0 : column_ff;
      is_nl    = (req_tdata == CHAR_NL);
      escaping = list_mode && !is_nl;
      nl_mark  = list_mode && is_nl && (fill_ff != 8'd0) && (last_ff == CHAR_SPACE);
      wrap     = escaping && (col0 >= WRAP_LIMIT);
      kind     = ESC_NONE;
      if (escaping) begin
         if (req_tdata == CHAR_BS || req_tdata == CHAR_TAB || req_tdata == CHAR_BSLASH)
            kind = ESC_PAIR;
         else if (req_tdata[7] || req_tdata < CHAR_SPACE || req_tdata == CHAR_DEL)
            kind = ESC_OCTAL;
      end
      len      = esc_len(kind) + (wrap ? 3'd3 : (nl_mark ? 3'd2 : 3'd0));
      fin      = final_byte(req_tdata, kind);
      fill_sum = fill_ff + {5'b0, len};
      flush    = (fin == CHAR_NL) || (fill_sum >= FLUSH_LIMIT);

      // column advances by the escape length (plain character is one)
      if (escaping)
         column_in = (wrap ? TAB_COL : col0) + {5'b0, esc_len(kind)};
      else
         column_in = col0;
      fill_in = flush ? 8'd0 : fill_sum;
      last_in = fin;

      q_desc.wrap      = wrap;
      q_desc.nl_mark   = nl_mark;
      q_desc.kind      = kind;
      q_desc.char_code = req_tdata;
      q_desc.len       = len;
      q_desc.flush     = flush;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 8'd0;
         fill_ff   <= 8'd0;
         last_ff   <= 8'd0;
      end else if (accept) begin
         column_ff <= column_in;
         fill_ff   <= fill_in;
         last_ff   <= last_in;
      end
   end

endmodule

[hw/rtl/lce_queue.sv]
// Short descriptor queue between front and back end.
// Depends on lce_pkg for the descriptor type and depth.
`timescale 1ns / 1ps

module lce_queue import lce_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  desc_type in_desc,
   output logic     out_valid,
   input  logic     out_ready,
   output desc_type out_desc
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push;
   logic                pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_desc  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_desc;
   end

endmodule

[hw/rtl/lce_back.sv]
// Back end: expands one descriptor into its output bytes, one per cycle while
// the receiver is ready, through a registered output stage. Depends on lce_pkg.
`timescale 1ns / 1ps

module lce_back import lce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   output logic       q_ready,
   input  desc_type   q_desc,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // byte_out
   output logic       rsp_tuser,   // flush_after
   output logic       rsp_tlast    // last_of_run
);

   logic [7:0] seq [7];
   logic [2:0] k;
   logic [7:0] fin;
   logic [2:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       flush_ff, flush_in;
   logic       last_ff, last_in;
   logic       out_load;
   logic       is_last;

   // Byte sequence of the head descriptor
   always_comb begin
      for (int i = 0; i < 7; i++) seq[i] = 8'd0;
      k   = 3'd0;
      fin = final_byte(q_desc.char_code, q_desc.kind);
      if (q_desc.nl_mark) begin
         seq[0] = CHAR_BSLASH;
         seq[1] = CHAR_LC_N;
         k      = 3'd2;
      end else if (q_desc.wrap) begin
         seq[0] = CHAR_BSLASH;
         seq[1] = CHAR_NL;
         seq[2] = CHAR_TAB;
         k      = 3'd3;
      end
      unique case (q_desc.kind)
         ESC_PAIR: begin
            seq[k]         = CHAR_BSLASH;
            seq[3'(k + 1)] = fin;
         end
         ESC_OCTAL: begin
            seq[k]         = CHAR_BSLASH;
            seq[3'(k + 1)] = CHAR_ZERO | {6'b0, q_desc.char_code[7:6]};
            seq[3'(k + 2)] = CHAR_ZERO | {5'b0, q_desc.char_code[5:3]};
            seq[3'(k + 3)] = fin;
         end
         default: seq[k] = fin;
      endcase
   end

   // Output stage and position counter
   always_comb begin
      out_load = !valid_ff || rsp_tready;
      is_last  = (pos_ff == q_desc.len - 3'd1);
      q_ready  = out_load && is_last;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      flush_in = flush_ff;
      last_in  = last_ff;
      if (out_load) begin
         valid_in = q_valid;
         data_in  = seq[pos_ff];
         flush_in = is_last && q_desc.flush;
         last_in  = is_last;
         if (q_valid) pos_in = is_last ? 3'd0 : pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      flush_ff <= flush_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = flush_ff;
   assign rsp_tlast  = last_ff;

endmodule

[hw/rtl/list_mode_char_escaper.sv]
// List-mode character escaper, top level: register port, front, queue, back.
// Path: a taken character is written into the queue, then registered in the back end's output stage.
// Output: one byte per cycle while the receiver is ready; a character expands to 1 to 7
// bytes, sent through the back end's single output stage.
// The front takes a character every cycle while the 4-entry queue has room.
// Synchronous reset clears list mode, column, fill count and last byte.
`timescale 1ns / 1ps

module list_mode_char_escaper import lce_pkg::*; #(
   parameter int LINE_CHARS = 72,
   parameter int TAB_CHARS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   // input characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_in
   input  logic        req_tuser,    // [0] line_start
   // output bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] byte_out
   output logic        rsp_tuser,    // [0] flush_after
   output logic        rsp_tlast,    // last_of_run
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic     list_mode_ff, list_mode_in;
   logic     csr_write;
   logic     fq_valid, fq_ready;
   desc_type fq_desc;
   logic     qb_valid, qb_ready;
   desc_type qb_desc;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == CSR_IDX_LIST_MODE);
   assign list_mode_in = csr_write ? csr_pwdata[0] : list_mode_ff;
   assign csr_prdata   = (csr_paddr[2] == CSR_IDX_LIST_MODE) ?
                         {31'b0, list_mode_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) list_mode_ff <= 1'b0;
      else list_mode_ff <= list_mode_in;
   end

   lce_front #(
      .LINE_CHARS (LINE_CHARS),
      .TAB_CHARS  (TAB_CHARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .list_mode  (list_mode_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (fq_valid),
      .q_ready    (fq_ready),
      .q_desc     (fq_desc)
   );

   lce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_desc   (fq_desc),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_desc  (qb_desc)
   );

   lce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (qb_valid),
      .q_ready    (qb_ready),
      .q_desc     (qb_desc),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hw/rtl/lce_checker.sv]
// Port-level checker for the list-mode character escaper, bound to the top.
// Depends on lce_pkg and list_mode_char_escaper_assert.svh.
`timescale 1ns / 1ps
`include "list_mode_char_escaper_assert.svh"

module lce_checker import lce_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // A stalled transaction keeps its byte
   `LCE_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp byte changed while stalled")

   // Flush only ever on the final byte of a character
   `LCE_ASSERT(a_flush_last, rsp_tvalid && rsp_tuser |-> rsp_tlast, "flush on a non-final byte")

   // A final newline always flushes the buffer
   `LCE_ASSERT(a_nl_flush, rsp_tvalid && rsp_tlast && rsp_tdata == CHAR_NL |-> rsp_tuser, "final newline without flush")

   // No output right after reset
   `LCE_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "output valid after reset")

endmodule

bind list_mode_char_escaper lce_checker u_lce_checker (.*);

[dv/list_mode_char_escaper_tb.sv]
// Testbench for list_mode_char_escaper: directed and random character streams,
// checked byte by byte against an in-bench model of the escaping rules.
// Depends on lce_pkg and the list_mode_char_escaper RTL.
`timescale 1ns / 1ps

module list_mode_char_escaper_tb;
   import lce_pkg::*;

   localparam int LINE_CHARS  = 72;
   localparam int TAB_CHARS   = 8;
   localparam int WRAP_LIMIT  = LINE_CHARS - 6;
   localparam int FLUSH_LIMIT = LINE_CHARS - 6;
   localparam int IDLE_CYCLES = 10;

   localparam logic [2:0] ADDR_LIST_MODE = {CSR_IDX_LIST_MODE, 2'b00};
   localparam logic [2:0] ADDR_SPARE     = {~CSR_IDX_LIST_MODE, 2'b00};

   typedef struct packed {
      logic [7:0] ch;
      logic       line_start;
   } char_item_type;

   typedef struct packed {
      logic [7:0] value;
      logic       flush;
      logic       run_end;
   } line_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] char_in
   logic        req_tuser = 1'b0;     // [0] line_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // [7:0] byte_out
   logic        rsp_tuser;            // [0] flush_after
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Model state
   logic       list_mode_on = 1'b0;
   logic [7:0] col_count = 8'd0;
   logic [7:0] fill_count = 8'd0;
   logic [7:0] last_buffered = 8'd0;

   char_item_type pending_chars[$];
   line_byte_type expected_bytes[$];
   int            error_count = 0;

   list_mode_char_escaper #(
      .LINE_CHARS(LINE_CHARS),
      .TAB_CHARS (TAB_CHARS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Non-final byte of a character's expansion
   task automatic buffer_byte(input logic [7:0] b);
      fill_count++;
      last_buffered = b;
      expected_bytes.push_back('{b, 1'b0, 1'b0});
   endtask

   // Expand one accepted character into the bytes it puts in the line buffer
   task automatic escape_char(input logic [7:0] ch, input logic line_start);
      logic [7:0] c;
      logic       flush;
      c = ch;
      if (line_start) col_count = 8'd0;
      if (list_mode_on) begin
         if (c == CHAR_NL) begin
            // visible marker for trailing space
            if (fill_count != 8'd0 && last_buffered == CHAR_SPACE) begin
               buffer_byte(CHAR_BSLASH);
               buffer_byte(CHAR_LC_N);
            end
         end else begin
            // wrap long lines before the character
            if (col_count >= WRAP_LIMIT) begin
               buffer_byte(CHAR_BSLASH);
               buffer_byte(CHAR_NL);
               buffer_byte(CHAR_TAB);
               col_count = 8'(TAB_CHARS);
            end
            col_count++;
            if (c == CHAR_BS || c == CHAR_BSLASH || c == CHAR_TAB) begin
               buffer_byte(CHAR_BSLASH);
               c = (c == CHAR_BS) ? CHAR_LC_B : (c == CHAR_TAB) ? CHAR_LC_T : CHAR_BSLASH;
               col_count++;
            end else if (c[7] || c < CHAR_SPACE || c == CHAR_DEL) begin
               buffer_byte(CHAR_BSLASH);
               buffer_byte(CHAR_ZERO + {6'd0, c[7:6]});
               buffer_byte(CHAR_ZERO + {5'd0, c[5:3]});
               c = CHAR_ZERO + {5'd0, c[2:0]};
               col_count += 8'd3;
            end
         end
      end
      // final byte carries the flush decision
      fill_count++;
      last_buffered = c;
      flush = (c == CHAR_NL) || (fill_count >= FLUSH_LIMIT);
      if (flush) fill_count = 8'd0;
      expected_bytes.push_back('{c, flush, 1'b1});
   endtask

   // Driver: bursts of transactions separated by random gaps
   int burst_left = 4;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            escape_char(req_tdata, req_tuser);
            void'(pending_chars.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_chars.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_chars[0].ch;
            req_tuser  <= pending_chars[0].line_start;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: receiver stall pattern and byte checks
   int stall_mode = 0;
   int mode_left = 40;

   always @(posedge clock) begin : byte_monitor
      line_byte_type want;
      if (mode_left == 0) begin
         stall_mode = $urandom_range(2);
         mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(1) == 0);
         default: rsp_tready <= ($urandom_range(4) == 0);
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_tdata));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.value)
               report_mismatch($sformatf("byte_out %02h, expected %02h",
                                         rsp_tdata, want.value));
            if (rsp_tuser !== want.flush)
               report_mismatch($sformatf("flush_after %b, expected %b on byte %02h",
                                         rsp_tuser, want.flush, want.value));
            if (rsp_tlast !== want.run_end)
               report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
                                         rsp_tlast, want.run_end, want.value));
         end
      end
   end

   // Register write followed by a readback of list mode
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_LIST_MODE) list_mode_on = value[0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_LIST_MODE;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[0] !== list_mode_on)
         report_mismatch($sformatf("list_mode reads %b, expected %b",
                                   csr_prdata[0], list_mode_on));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Hold off until every byte has come back
   task automatic wait_idle();
      while (pending_chars.size() != 0 || req_tvalid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_char(input logic [7:0] ch, input logic line_start);
      pending_chars.push_back('{ch, line_start});
   endtask

   function automatic logic [7:0] random_char();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 8'($urandom_range(8'h21, 8'h7E));
      if (r < 75) return CHAR_SPACE;
      if (r < 83) return 8'($urandom_range(8'h00, 8'h1F));
      if (r < 91) return 8'($urandom_range(8'h80, 8'hFF));
      if (r < 93) return CHAR_BSLASH;
      if (r < 95) return CHAR_DEL;
      return 8'($urandom_range(255));
   endfunction

   // Lines of random text, mostly short, some long enough to wrap and fill the buffer
   task automatic queue_random_text(input int n);
      int made;
      int len;
      made = 0;
      while (made < n) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 20);
         for (int i = 0; i < len && made < n; i++) begin
            queue_char(random_char(),
                       (i == 0) ? 1'($urandom_range(1)) : 1'($urandom_range(30) == 0));
            made++;
         end
         if (made < n) begin
            queue_char(CHAR_NL, 1'($urandom_range(9) == 0));
            made++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // pass-through with list mode off after reset
      queue_char(8'h00, 1'b0);
      queue_char(8'hFF, 1'b1);
      queue_char(CHAR_NL, 1'b0);
      queue_char(CHAR_BSLASH, 1'b0);
      queue_char(CHAR_DEL, 1'b0);
      wait_idle();

      // escapes, octal, newline markers with list mode on
      csr_write(ADDR_LIST_MODE, 32'd1);
      queue_char(CHAR_BS, 1'b1);
      queue_char(CHAR_TAB, 1'b0);
      queue_char(CHAR_BSLASH, 1'b0);
      queue_char(8'h00, 1'b0);
      queue_char(8'h1F, 1'b0);
      queue_char(CHAR_DEL, 1'b0);
      queue_char(8'h80, 1'b0);
      queue_char(8'hFF, 1'b0);
      queue_char(8'h41, 1'b0);
      queue_char(CHAR_SPACE, 1'b0);
      queue_char(CHAR_NL, 1'b0);       // marker: space buffered
      queue_char(CHAR_NL, 1'b0);       // no marker: buffer empty
      queue_char(CHAR_SPACE, 1'b1);
      queue_char(8'h78, 1'b0);
      queue_char(CHAR_NL, 1'b0);       // no marker: last byte not space
      wait_idle();

      queue_random_text(60);
      wait_idle();
      queue_random_text(30);
      wait_idle();

      // unused address is ignored, only bit 0 of the data counts
      csr_write(ADDR_SPARE, 32'd0);
      csr_write(ADDR_LIST_MODE, 32'hFFFF_FFFE);
      queue_random_text(40);
      wait_idle();

      csr_write(ADDR_LIST_MODE, 32'hFFFF_FFFF);
      queue_random_text(60);
      wait_idle();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/lce_pkg.sv
hw/rtl/lce_front.sv
hw/rtl/lce_queue.sv
hw/rtl/lce_back.sv
hw/rtl/list_mode_char_escaper.sv
hw/rtl/lce_checker.sv
dv/list_mode_char_escaper_tb.sv
